// File: rtl/amsg_pkg.sv
// shared types, widths and constants for the amsgrad parameter update block
`timescale 1ns / 1ps
`default_nettype none

package amsg_pkg;

  // sizes of the element store and the input queue
  localparam int ELEMENT_COUNT_DEF = 4096;
  localparam int QUEUE_DEPTH       = 4;

  // field and register widths
  localparam int IDX_W      = 12;
  localparam int GRAD_W     = 32;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam int ALPHA_W    = 24;
  localparam int BETA_W     = 16;
  localparam int EPS_W      = 16;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 2;

  // datapath widths
  localparam int ROOT_W = 24;
  localparam int REM_W  = ROOT_W + 2;
  localparam int NUM_W  = 56;
  localparam int D_W    = ROOT_W + 1;
  localparam int DEN_W  = D_W + 8;
  localparam int N_W    = NUM_W + 1;
  localparam int Q_W    = 32;

  // saturation limits of the update value
  localparam logic [OUT_DATA_W-1:0] UPD_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_DATA_W-1:0] UPD_NEG_MAX = 32'h8000_0000;

  // register reset values
  localparam logic [ALPHA_W-1:0] LEARNING_RATE_RST = 24'd16777;
  localparam logic [BETA_W-1:0]  FIRST_DECAY_RST   = 16'd58982;
  localparam logic [BETA_W-1:0]  SECOND_DECAY_RST  = 16'd65470;
  localparam logic [EPS_W-1:0]   STABILIZER_RST    = 16'd1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARNING_RATE = 2'd0,
    REG_FIRST_DECAY   = 2'd1,
    REG_SECOND_DECAY  = 2'd2,
    REG_STABILIZER    = 2'd3
  } cfg_reg_t;

  // one classified input beat
  typedef struct packed {
    logic [IDX_W-1:0]  element_index;
    logic              in_range;
    logic [GRAD_W-1:0] gradient;
  } item_t;

  // head of the input queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // back end status seen by the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  // per element moments as stored
  typedef struct packed {
    logic [31:0] m;
    logic [31:0] v;
    logic [31:0] vmax;
  } moments_t;

  // result of the moment update
  typedef struct packed {
    logic        in_range;
    logic        sq_sat;
    logic [31:0] m;
    logic [31:0] vmax;
  } upd_t;

  // flags carried down the root and divide pipelines
  typedef struct packed {
    logic in_range;
    logic sq_sat;
    logic m_neg;
    logic num_zero;
  } tag_t;

  // result of the square root pipeline
  typedef struct packed {
    tag_t              tag;
    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] root;
  } root_res_t;

endpackage

`default_nettype wire

// File: rtl/amsgrad_param_update.sv
// amsgrad update: one beat a cycle when unstalled, with input held off during the clearing pass
// back end is one in-order pipeline: squaring, moment read-modify-write, 24-stage root, 33-stage divide
// throughput one beat per cycle if unstalled; same-index beats back to back are forwarded in the moment stage
// a 4-entry queue takes input beats while the result beat waits
// rst is synchronous; after it the moment store is zeroed entry by entry with input held off
`timescale 1ns / 1ps
`default_nettype none

module amsgrad_param_update #(
  parameter int ELEMENT_COUNT = amsg_pkg::ELEMENT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [amsg_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // element_index[11:0], gradient[43:12]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [amsg_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // update_value[31:0]
  output logic                            m_axis_tuser,   // saturated[0]
  input  logic                            cfg_we,
  input  logic [amsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [amsg_pkg::CFG_W-1:0]      cfg_data
);

  logic [amsg_pkg::ALPHA_W-1:0] learning_rate;
  logic [amsg_pkg::BETA_W-1:0]  first_decay;
  logic [amsg_pkg::BETA_W-1:0]  second_decay;
  logic [amsg_pkg::EPS_W-1:0]   stabilizer;

  logic                  en;
  amsg_pkg::queue_head_t head;
  amsg_pkg::back_stat_t  stat;
  logic                  upd_valid;
  amsg_pkg::upd_t        upd;
  logic                  rt_valid;
  amsg_pkg::root_res_t   rt_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= amsg_pkg::LEARNING_RATE_RST;
      first_decay   <= amsg_pkg::FIRST_DECAY_RST;
      second_decay  <= amsg_pkg::SECOND_DECAY_RST;
      stabilizer    <= amsg_pkg::STABILIZER_RST;
    end else if (cfg_we) begin
      unique case (amsg_pkg::cfg_reg_t'(cfg_index))
        amsg_pkg::REG_LEARNING_RATE: learning_rate <= cfg_data[amsg_pkg::ALPHA_W-1:0];
        amsg_pkg::REG_FIRST_DECAY:   first_decay   <= cfg_data[amsg_pkg::BETA_W-1:0];
        amsg_pkg::REG_SECOND_DECAY:  second_decay  <= cfg_data[amsg_pkg::BETA_W-1:0];
        amsg_pkg::REG_STABILIZER:    stabilizer    <= cfg_data[amsg_pkg::EPS_W-1:0];
      endcase
    end
  end

  // back end advances whenever the output register can take a beat
  assign en = !m_axis_tvalid || m_axis_tready;

  amsg_front #(
    .ELEMENT_COUNT (ELEMENT_COUNT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .stat          (stat),
    .head          (head)
  );

  amsg_moment #(
    .ELEMENT_COUNT (ELEMENT_COUNT)
  ) u_moment (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .first_decay  (first_decay),
    .second_decay (second_decay),
    .head         (head),
    .stat         (stat),
    .upd_valid    (upd_valid),
    .upd          (upd)
  );

  amsg_root u_root (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .learning_rate (learning_rate),
    .upd_valid     (upd_valid),
    .upd           (upd),
    .rt_valid      (rt_valid),
    .rt_out        (rt_out)
  );

  amsg_div u_div (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .stabilizer    (stabilizer),
    .rt_valid      (rt_valid),
    .rt_out        (rt_out),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // no input beat is taken while the store is being cleared
  assert property (@(posedge clk) disable iff (rst) stat.clearing |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

  // the back end pops only a filled queue
  assert property (@(posedge clk) disable iff (rst) stat.pop |-> head.valid)
    else $error("pop from empty queue");

  // every reset starts a clearing pass
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> stat.clearing)
    else $error("clearing pass missing after reset");

endmodule

`default_nettype wire

// File: rtl/amsg_front.sv
// input side: accepts beats, range-checks the index and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none

module amsg_front #(
  parameter int ELEMENT_COUNT = amsg_pkg::ELEMENT_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [amsg_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  amsg_pkg::back_stat_t           stat,
  output amsg_pkg::queue_head_t          head
);

  localparam int PW = $clog2(amsg_pkg::QUEUE_DEPTH);

  amsg_pkg::item_t slots [amsg_pkg::QUEUE_DEPTH];
  amsg_pkg::item_t in_item;
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            push;

  // classify the incoming beat
  always_comb begin
    in_item.element_index = s_axis_tdata[amsg_pkg::IDX_W-1:0];
    in_item.gradient      = s_axis_tdata[amsg_pkg::IDX_W +: amsg_pkg::GRAD_W];
    in_item.in_range      = 32'(s_axis_tdata[amsg_pkg::IDX_W-1:0]) < 32'(ELEMENT_COUNT);
  end

  assign s_axis_tready = !stat.clearing && (count != (PW+1)'(amsg_pkg::QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (stat.pop) rd_ptr <= rd_ptr + PW'(1);
      count <= count + (PW+1)'(push) - (PW+1)'(stat.pop);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end

  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

endmodule

`default_nettype wire

// File: rtl/amsg_moment.sv
// moment store with clearing pass, gradient square and read-modify-write of m, v, vmax
`timescale 1ns / 1ps
`default_nettype none

module amsg_moment #(
  parameter int ELEMENT_COUNT = amsg_pkg::ELEMENT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [amsg_pkg::BETA_W-1:0] first_decay,
  input  logic [amsg_pkg::BETA_W-1:0] second_decay,
  input  amsg_pkg::queue_head_t       head,
  output amsg_pkg::back_stat_t        stat,
  output logic                        upd_valid,
  output amsg_pkg::upd_t              upd
);

  localparam int AW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;

  amsg_pkg::moments_t mem [ELEMENT_COUNT];

  logic                  clr_busy;
  logic [AW-1:0]         clr_addr;
  logic                  pop;
  logic [31:0]           g_mag;

  logic                  s0_valid;
  amsg_pkg::item_t       s0_item;
  logic [63:0]           s0_prod;
  logic [AW-1:0]         s0_addr;
  logic [64:0]           sq_sum;
  logic [48:0]           sq_full;
  logic                  sq_sat;
  logic [31:0]           sq;

  logic                  s1_valid;
  amsg_pkg::item_t       s1_item;
  logic [31:0]           s1_sq;
  logic                  s1_sq_sat;
  amsg_pkg::moments_t    s1_rd;
  logic [AW-1:0]         s1_addr;

  logic                  fwd_valid;
  logic [AW-1:0]         fwd_addr;
  amsg_pkg::moments_t    fwd_data;

  amsg_pkg::moments_t    cur;
  amsg_pkg::moments_t    nxt;
  logic [16:0]           om1;
  logic [16:0]           om2;
  logic signed [32:0]    m_diff;
  logic signed [32:0]    v_diff;
  logic signed [50:0]    m_prod;
  logic signed [50:0]    v_prod;
  logic signed [50:0]    m_step;
  logic signed [50:0]    v_step;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  amsg_pkg::moments_t    wr_data;

  // clearing pass over the store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == AW'(ELEMENT_COUNT - 1)) clr_busy <= 1'b0;
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign pop           = en && head.valid && !clr_busy;
  assign stat.pop      = pop;
  assign stat.clearing = clr_busy;

  // magnitude of the gradient for squaring
  assign g_mag = head.item.gradient[31] ? (~head.item.gradient + 32'd1) : head.item.gradient;

  // stage 0: square the gradient
  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else if (en) s0_valid <= pop;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_item <= head.item;
      s0_prod <= 64'(g_mag) * 64'(g_mag);
    end
  end

  // round and saturate the square
  always_comb begin
    sq_sum  = {1'b0, s0_prod} + 65'd32768;
    sq_full = sq_sum[64:16];
    sq_sat  = |sq_full[48:32];
    sq      = sq_sat ? '1 : sq_full[31:0];
  end

  assign s0_addr = AW'(s0_item.element_index);

  // stage 1 control and payload
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= s0_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item   <= s0_item;
      s1_sq     <= sq;
      s1_sq_sat <= sq_sat;
    end
  end

  assign s1_addr = AW'(s1_item.element_index);

  // forward the value written at the edge this item read the store
  assign cur = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : s1_rd;

  // blends rewritten as old + (1-beta)*(new-old)
  always_comb begin
    om1    = 17'(17'd65536 - {1'b0, first_decay});
    om2    = 17'(17'd65536 - {1'b0, second_decay});
    m_diff = $signed({s1_item.gradient[31], s1_item.gradient}) - $signed({cur.m[31], cur.m});
    v_diff = $signed({1'b0, s1_sq}) - $signed({1'b0, cur.v});
    m_prod = $signed({1'b0, om1}) * m_diff;
    v_prod = $signed({1'b0, om2}) * v_diff;
    m_step = (m_prod + 51'sd32768) >>> 16;
    v_step = (v_prod + 51'sd32768) >>> 16;
    nxt.m    = cur.m + m_step[31:0];
    nxt.v    = cur.v + v_step[31:0];
    nxt.vmax = (nxt.v > cur.vmax) ? nxt.v : cur.vmax;
  end

  // write port: clearing pass or update
  always_comb begin
    wr_en   = clr_busy || (en && s1_valid && s1_item.in_range);
    wr_addr = clr_busy ? clr_addr : s1_addr;
    wr_data = clr_busy ? '0 : nxt;
  end

  // store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (en) s1_rd <= mem[s0_addr];
  end

  // forwarding register
  always_ff @(posedge clk) begin
    if (rst) fwd_valid <= 1'b0;
    else if (en) fwd_valid <= s1_valid && s1_item.in_range;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_addr <= s1_addr;
      fwd_data <= nxt;
    end
  end

  assign upd_valid    = s1_valid;
  assign upd.in_range = s1_item.in_range;
  assign upd.sq_sat   = s1_sq_sat;
  assign upd.m        = nxt.m;
  assign upd.vmax     = nxt.vmax;

endmodule

`default_nettype wire

// File: rtl/amsg_root.sv
// numerator product and digit-by-digit square root of vmax, one root bit a stage
`timescale 1ns / 1ps
`default_nettype none

module amsg_root (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [amsg_pkg::ALPHA_W-1:0] learning_rate,
  input  logic                         upd_valid,
  input  amsg_pkg::upd_t               upd,
  output logic                         rt_valid,
  output amsg_pkg::root_res_t          rt_out
);

  localparam int RW = amsg_pkg::ROOT_W;
  localparam int XW = 2 * RW;

  logic              p_valid;
  amsg_pkg::upd_t    p;
  logic [31:0]       p_mag;
  amsg_pkg::tag_t    p_tag;

  logic                            st_valid [RW];
  logic [amsg_pkg::REM_W-1:0]      st_rem   [RW];
  logic [RW-1:0]                   st_root  [RW];
  logic [XW-1:0]                   st_x     [RW];
  amsg_pkg::tag_t                  st_tag   [RW];
  logic [amsg_pkg::NUM_W-1:0]      st_num   [RW];

  // register the moment update
  always_ff @(posedge clk) begin
    if (rst) p_valid <= 1'b0;
    else if (en) p_valid <= upd_valid;
  end

  always_ff @(posedge clk) begin
    if (en) p <= upd;
  end

  assign p_mag          = p.m[31] ? (~p.m + 32'd1) : p.m;
  assign p_tag.in_range = p.in_range;
  assign p_tag.sq_sat   = p.sq_sat;
  assign p_tag.m_neg    = p.m[31];
  assign p_tag.num_zero = (learning_rate == '0) || (p.m == '0);

  // root stages, most significant pair first
  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [amsg_pkg::REM_W-1:0]   rem_in;
    logic [RW-1:0]                root_in;
    logic [XW-1:0]                x_in;
    logic [amsg_pkg::REM_W+1:0]   cand;
    logic [amsg_pkg::REM_W+1:0]   trial;
    logic                         ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = {p.vmax, 16'd0};
    end else begin : g_next
      assign rem_in  = st_rem[k-1];
      assign root_in = st_root[k-1];
      assign x_in    = st_x[k-1];
    end

    assign cand  = {rem_in, x_in[2*(RW-1-k)+1 -: 2]};
    assign trial = (amsg_pkg::REM_W+2)'({root_in, 2'b01});
    assign ge    = cand >= trial;

    always_ff @(posedge clk) begin
      if (rst) st_valid[k] <= 1'b0;
      else if (en) st_valid[k] <= (k == 0) ? p_valid : st_valid[(k == 0) ? 0 : k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[k]  <= ge ? amsg_pkg::REM_W'(cand - trial) : amsg_pkg::REM_W'(cand);
        st_root[k] <= {root_in[RW-2:0], ge};
        st_x[k]    <= x_in;
        if (k == 0) begin
          st_tag[k] <= p_tag;
          st_num[k] <= amsg_pkg::NUM_W'(learning_rate) * amsg_pkg::NUM_W'(p_mag);
        end else begin
          st_tag[k] <= st_tag[(k == 0) ? 0 : k-1];
          st_num[k] <= st_num[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign rt_valid    = st_valid[RW-1];
  assign rt_out.tag  = st_tag[RW-1];
  assign rt_out.num  = st_num[RW-1];
  assign rt_out.root = st_root[RW-1];

endmodule

`default_nettype wire

// File: rtl/amsg_div.sv
// denominator, rounded restoring division one quotient bit a stage, saturation and output register
`timescale 1ns / 1ps
`default_nettype none

module amsg_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [amsg_pkg::EPS_W-1:0]      stabilizer,
  input  logic                            rt_valid,
  input  amsg_pkg::root_res_t             rt_out,
  output logic                            m_axis_tvalid,
  output logic [amsg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser
);

  localparam int QW = amsg_pkg::Q_W;
  localparam int DW = amsg_pkg::DEN_W;

  logic                         da_valid;
  logic [amsg_pkg::D_W-1:0]     da_d;
  logic [amsg_pkg::NUM_W-1:0]   da_num;
  amsg_pkg::tag_t               da_tag;
  logic [amsg_pkg::N_W-1:0]     n_full;
  logic [DW-1:0]                den0;

  logic            dv_valid [QW+1];
  logic [DW-1:0]   dv_rem   [QW+1];
  logic [QW-1:0]   dv_n     [QW+1];
  logic [DW-1:0]   dv_den   [QW+1];
  logic [QW-1:0]   dv_q     [QW+1];
  logic            dv_ovf   [QW+1];
  logic            dv_dz    [QW+1];
  amsg_pkg::tag_t  dv_tag   [QW+1];

  amsg_pkg::tag_t                  f_tag;
  logic [QW-1:0]                   f_q;
  logic [amsg_pkg::OUT_DATA_W-1:0] res;
  logic                            res_sat;

  // denominator: root plus epsilon
  always_ff @(posedge clk) begin
    if (rst) da_valid <= 1'b0;
    else if (en) da_valid <= rt_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      da_d   <= amsg_pkg::D_W'(rt_out.root) + amsg_pkg::D_W'(stabilizer);
      da_num <= rt_out.num;
      da_tag <= rt_out.tag;
    end
  end

  // rounding bias, scaled divisor and overflow check
  assign n_full = amsg_pkg::N_W'(da_num) + amsg_pkg::N_W'({da_d, 7'd0});
  assign den0   = {da_d, 8'd0};

  always_ff @(posedge clk) begin
    if (rst) dv_valid[0] <= 1'b0;
    else if (en) dv_valid[0] <= da_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0] <= DW'(n_full[amsg_pkg::N_W-1:QW]);
      dv_n[0]   <= n_full[QW-1:0];
      dv_den[0] <= den0;
      dv_q[0]   <= '0;
      dv_ovf[0] <= DW'(n_full[amsg_pkg::N_W-1:QW]) >= den0;
      dv_dz[0]  <= (da_d == '0);
      dv_tag[0] <= da_tag;
    end
  end

  // division stages
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] r2;
    logic        ge;

    assign r2 = {dv_rem[k-1], dv_n[k-1][QW-1]};
    assign ge = r2 >= {1'b0, dv_den[k-1]};

    always_ff @(posedge clk) begin
      if (rst) dv_valid[k] <= 1'b0;
      else if (en) dv_valid[k] <= dv_valid[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[k] <= ge ? DW'(r2 - {1'b0, dv_den[k-1]}) : r2[DW-1:0];
        dv_n[k]   <= {dv_n[k-1][QW-2:0], 1'b0};
        dv_den[k] <= dv_den[k-1];
        dv_q[k]   <= {dv_q[k-1][QW-2:0], ge};
        dv_ovf[k] <= dv_ovf[k-1];
        dv_dz[k]  <= dv_dz[k-1];
        dv_tag[k] <= dv_tag[k-1];
      end
    end
  end

  // sign, saturation and special cases
  assign f_tag = dv_tag[QW];
  assign f_q   = dv_q[QW];

  always_comb begin
    res     = '0;
    res_sat = 1'b0;
    if (!f_tag.in_range) begin
      res     = '0;
      res_sat = 1'b0;
    end else if (f_tag.num_zero) begin
      res     = '0;
      res_sat = f_tag.sq_sat;
    end else if (dv_dz[QW]) begin
      res     = f_tag.m_neg ? amsg_pkg::UPD_POS_MAX : amsg_pkg::UPD_NEG_MAX;
      res_sat = 1'b1;
    end else if (!f_tag.m_neg) begin
      if (dv_ovf[QW] || f_q > amsg_pkg::UPD_NEG_MAX) begin
        res     = amsg_pkg::UPD_NEG_MAX;
        res_sat = 1'b1;
      end else begin
        res     = ~f_q + 32'd1;
        res_sat = f_tag.sq_sat;
      end
    end else begin
      if (dv_ovf[QW] || f_q > amsg_pkg::UPD_POS_MAX) begin
        res     = amsg_pkg::UPD_POS_MAX;
        res_sat = 1'b1;
      end else begin
        res     = f_q;
        res_sat = f_tag.sq_sat;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= dv_valid[QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= res;
      m_axis_tuser <= res_sat;
    end
  end

endmodule

`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench for the amsgrad parameter update block
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_ELEM = 4096;
  localparam int PIPE_LAT = 62;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [amsg_pkg::IN_DATA_W-1:0] s_axis_tdata;   // element_index[11:0], gradient[43:12]
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [amsg_pkg::OUT_DATA_W-1:0] m_axis_tdata;  // update_value[31:0]
  logic m_axis_tuser;                             // saturated[0]
  logic cfg_we;
  logic [amsg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [amsg_pkg::CFG_W-1:0] cfg_data;

  amsgrad_param_update uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model copy of registers and moment stores
  logic [23:0] alpha_q;
  logic [15:0] beta1_q, beta2_q, eps_q;
  logic signed [31:0] m_store [NUM_ELEM];
  logic [31:0] v_store [NUM_ELEM];
  logic [31:0] vmax_store [NUM_ELEM];

  typedef struct {
    logic [31:0] upd;
    logic sat;
  } update_t;
  update_t pending_updates[$];

  int errors = 0;
  int idle_pct = 9;
  int stall_cycles = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // compute one update and advance the moment stores
  function automatic update_t amsgrad_step(logic [11:0] idx, logic [31:0] graw);
    update_t r;
    longint g, m, acc, res;
    longint unsigned mag, sq, v, vm, d, num, den, q;
    g = longint'(signed'(graw));
    r.sat = 0;
    r.upd = 0;
    if (idx >= NUM_ELEM) return r;
    acc = longint'(beta1_q) * longint'(m_store[idx]) + longint'(65536 - beta1_q) * g + 32768;
    m = acc >>> 16;
    m_store[idx] = m[31:0];
    mag = (g < 0) ? -g : g;
    sq = (mag * mag + 32768) >> 16;
    if (sq > 64'hFFFF_FFFF) begin
      sq = 64'hFFFF_FFFF;
      r.sat = 1;
    end
    v = (64'(beta2_q) * v_store[idx] + 64'(65536 - beta2_q) * sq + 32768) >> 16;
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    v_store[idx] = v[31:0];
    vm = vmax_store[idx];
    if (v > vm) vm = v;
    vmax_store[idx] = vm[31:0];
    d = isqrt(vm << 16) + eps_q;
    mag = (m < 0) ? -m : m;
    num = 64'(alpha_q) * mag;
    if (num == 0) begin
      res = 0;
    end else if (d == 0) begin
      r.sat = 1;
      res = (m > 0) ? -64'sd2147483648 : 64'sd2147483647;
    end else begin
      den = d << 8;
      q = (num + den / 2) / den;
      if (m > 0) begin
        if (q > 64'd2147483648) begin
          q = 64'd2147483648;
          r.sat = 1;
        end
        res = -longint'(q);
      end else begin
        if (q > 64'd2147483647) begin
          q = 64'd2147483647;
          r.sat = 1;
        end
        res = longint'(q);
      end
    end
    r.upd = res[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result side: random backpressure and compare
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    update_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_updates.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, '0);
      end else begin
        want = pending_updates.pop_front();
        if (m_axis_tdata !== want.upd) report_mismatch("update_value", m_axis_tdata, want.upd);
        if (m_axis_tuser !== want.sat)
          report_mismatch("saturated", 32'(m_axis_tuser), 32'(want.sat));
      end
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // valid stays high after the beat so beats can follow back to back
  task automatic send_gradient(logic [11:0] idx, logic [31:0] g);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'd0, g, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_updates.push_back(amsgrad_step(idx, g));
    @(negedge clk);
  endtask

  task automatic drain_updates();
    s_axis_tvalid <= 0;
    while (pending_updates.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 8) @(negedge clk);
  endtask

  task automatic write_reg(amsg_pkg::cfg_reg_t r, logic [23:0] val);
    cfg_we <= 1;
    cfg_index <= r;
    cfg_data <= val;
    @(negedge clk);
    case (r)
      amsg_pkg::REG_LEARNING_RATE: alpha_q = val;
      amsg_pkg::REG_FIRST_DECAY: beta1_q = val[15:0];
      amsg_pkg::REG_SECOND_DECAY: beta2_q = val[15:0];
      amsg_pkg::REG_STABILIZER: eps_q = val[15:0];
    endcase
  endtask

  task automatic set_all(logic [23:0] a, logic [15:0] b1, logic [15:0] b2, logic [15:0] e);
    drain_updates();
    write_reg(amsg_pkg::REG_LEARNING_RATE, a);
    write_reg(amsg_pkg::REG_FIRST_DECAY, 24'(b1));
    write_reg(amsg_pkg::REG_SECOND_DECAY, 24'(b2));
    write_reg(amsg_pkg::REG_STABILIZER, 24'(e));
    cfg_we <= 0;
  endtask

  // field extremes, saturating squares, zero denominator
  task automatic test_directed();
    send_gradient(0, 0);
    send_gradient(12'hFFF, 32'h7FFF_FFFF);
    send_gradient(12'hFFF, 32'h8000_0000);
    send_gradient(1, 32'h0001_0000);
    send_gradient(1, 32'hFFFF_0000);
    send_gradient(2, 32'h0100_0000);
    send_gradient(2, 32'h0100_0000);
    set_all(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'h0);
    send_gradient(3, 32'h7FFF_FFFF);   // saturating square, positive m
    send_gradient(4, 32'h8000_0000);   // saturating square, negative m
    send_gradient(5, 0);
    set_all(24'hFFFFFF, 16'h0, 16'h0, 16'h0);
    send_gradient(6, 32'h0000_0001);
    send_gradient(6, 32'hFFFF_FFFF);
    send_gradient(7, 32'h7FFF_FFFF);
    send_gradient(7, 0);
    set_all(24'h0, 16'h8000, 16'h8000, 16'hFFFF);
    send_gradient(8, 32'h1234_5678);
  endtask

  // random gradients under several settings, indexes often reused
  task automatic test_random(int count);
    logic [11:0] idx;
    logic [31:0] g;
    for (int i = 0; i < count; i++) begin
      idx = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(15));
      case ($urandom_range(3))
        0: g = $urandom;
        1: g = 32'($signed($urandom_range(1 << 20)) - (1 << 19));
        2: g = {{16{1'($urandom_range(1))}}, 16'($urandom)};
        default: g = 32'($urandom_range(255)) << $urandom_range(31);
      endcase
      send_gradient(idx, g);
    end
  endtask

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    cfg_we = 0;
    cfg_index = amsg_pkg::REG_LEARNING_RATE;
    cfg_data = 0;
    alpha_q = amsg_pkg::LEARNING_RATE_RST;
    beta1_q = amsg_pkg::FIRST_DECAY_RST;
    beta2_q = amsg_pkg::SECOND_DECAY_RST;
    eps_q = amsg_pkg::STABILIZER_RST;
    for (int i = 0; i < NUM_ELEM; i++) begin
      m_store[i] = 0;
      v_store[i] = 0;
      vmax_store[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    set_all(amsg_pkg::LEARNING_RATE_RST, amsg_pkg::FIRST_DECAY_RST,
            amsg_pkg::SECOND_DECAY_RST, amsg_pkg::STABILIZER_RST);
    test_random(150);
    // sender pauses until every result is back
    drain_updates();
    idle_pct = 0;
    set_all(24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    test_random(150);
    idle_pct = 9;
    set_all(24'h000001, 16'hFFFF, 16'h0001, 16'h0);
    test_random(150);
    drain_updates();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
